### hw/rtl/ray_box_slab_test_3d_core_macros.svh
// Assertion macros for the ray/box slab test core.
`ifndef RAY_BOX_SLAB_TEST_3D_CORE_MACROS_SVH
`define RAY_BOX_SLAB_TEST_3D_CORE_MACROS_SVH
`ifndef SYNTH
`define RBS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define RBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define RBS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/rbs3d_pkg.sv
package rbs3d_pkg;

    localparam logic signed [31:0] FULL = 32'sh7FFF_FFFF;

    typedef enum logic [2:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MIN_Y = 3'd1,
        REG_BOX_MIN_Z = 3'd2,
        REG_BOX_MAX_X = 3'd3,
        REG_BOX_MAX_Y = 3'd4,
        REG_BOX_MAX_Z = 3'd5
    } t_reg;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] t_entry;
        logic signed [31:0] t_exit;
    } t_out;

    // one divider lane: unsigned restoring division, quotient built MSB first
    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] dvd;
        logic [30:0] q;
        logic [31:0] dmag;
        logic        neg;
        logic        ovf;
    } t_div;

    // lanes 2a and 2a+1 are the min and max bound of axis a
    typedef struct packed {
        t_div [5:0]         dv;
        logic [5:0][31:0]   t;
        logic [2:0]         dzero;
        logic [2:0]         dneg;
        logic [2:0]         in_slab;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic               ok;
    } t_stage;

    function automatic t_div div_step(t_div d);
        t_div        r;
        logic [32:0] rem2;
        r    = d;
        rem2 = {d.rem, d.dvd[30]};
        if (rem2 >= {1'b0, d.dmag}) begin
            rem2  = rem2 - {1'b0, d.dmag};
            r.q   = {d.q[29:0], 1'b1};
        end else begin
            r.q   = {d.q[29:0], 1'b0};
        end
        r.rem = rem2[31:0];
        r.dvd = {d.dvd[29:0], 1'b0};
        return r;
    endfunction

    function automatic t_stage axis_step(t_stage s, logic [1:0] a);
        t_stage             r;
        logic signed [31:0] tmn;
        logic signed [31:0] tmx;
        logic signed [31:0] f;
        logic signed [31:0] sc;
        r   = s;
        tmn = s.t[{a, 1'b0}];
        tmx = s.t[{a, 1'b1}];
        f   = s.dneg[a] ? tmn : tmx;
        sc  = s.dneg[a] ? tmx : tmn;
        if (s.ok) begin
            if (s.dzero[a]) begin
                r.ok = s.in_slab[a];
            end else if (f < s.lo) begin
                r.ok = 1'b0;
            end else begin
                if (f <= s.hi) r.hi = f;
                if (sc >= s.lo) begin
                    if (sc > r.hi) r.ok = 1'b0;
                    else r.lo = sc;
                end
            end
        end
        return r;
    endfunction

endpackage

### hw/rtl/ray_box_slab_test_3d_core.sv
// Ray against axis-aligned box, slab method, signed Q16.16.
// Input channel: i_in_valid / o_in_ready carry one ray (origin, direction).
// Output channel: o_out_valid / i_out_ready carry hit, t_entry, t_exit;
// a miss gives zeros in both parameters.
// The box bounds sit in six APB registers at byte addresses 0..20
// (min x, y, z, then max x, y, z); write them only while no ray is in flight.
// Throughput: one ray per cycle while the receiver does not stall. The
// pipeline is six 31-bit restoring dividers run four quotient bits per
// stage over eight stages, plus entry, range check, sign fix, three axis
// stages and the output register.
// When the receiver stalls, the whole pipeline holds and o_in_ready drops;
// nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and loads the unit
// box: min 0.0, max 1.0 on every axis.
module ray_box_slab_test_3d_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rbs3d_pkg::t_in       i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rbs3d_pkg::t_out      o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    `include "ray_box_slab_test_3d_core_macros.svh"

    localparam int unsigned QBITS  = 31;
    localparam int unsigned SPS    = 4;
    localparam int unsigned NDS    = (QBITS + SPS - 1) / SPS;
    localparam int unsigned S_DIV0 = 2;
    localparam int unsigned S_SIGN = S_DIV0 + NDS;
    localparam int unsigned S_AX0  = S_SIGN + 1;
    localparam int unsigned NS     = S_AX0 + 3;

    logic signed [31:0] r_box_min [3];
    logic signed [31:0] r_box_max [3];

    logic [NS-1:0]     r_v;
    rbs3d_pkg::t_stage r_s [NS];
    rbs3d_pkg::t_stage n_s [NS];
    logic              r_ov;
    rbs3d_pkg::t_out   r_o;
    rbs3d_pkg::t_out   n_o;
    logic              en;
    logic              in_xfer;

    assign en      = !r_ov || i_out_ready;
    assign in_xfer = i_in_valid && en;
    assign o_in_ready  = en;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_o;
    assign pready      = 1'b1;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_box_min[a] <= 32'sd0;
                r_box_max[a] <= 32'sh0001_0000;
            end
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                rbs3d_pkg::REG_BOX_MIN_X: r_box_min[0] <= pwdata;
                rbs3d_pkg::REG_BOX_MIN_Y: r_box_min[1] <= pwdata;
                rbs3d_pkg::REG_BOX_MIN_Z: r_box_min[2] <= pwdata;
                rbs3d_pkg::REG_BOX_MAX_X: r_box_max[0] <= pwdata;
                rbs3d_pkg::REG_BOX_MAX_Y: r_box_max[1] <= pwdata;
                rbs3d_pkg::REG_BOX_MAX_Z: r_box_max[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            rbs3d_pkg::REG_BOX_MIN_X: prdata = r_box_min[0];
            rbs3d_pkg::REG_BOX_MIN_Y: prdata = r_box_min[1];
            rbs3d_pkg::REG_BOX_MIN_Z: prdata = r_box_min[2];
            rbs3d_pkg::REG_BOX_MAX_X: prdata = r_box_max[0];
            rbs3d_pkg::REG_BOX_MAX_Y: prdata = r_box_max[1];
            rbs3d_pkg::REG_BOX_MAX_Z: prdata = r_box_max[2];
            default:                  prdata = 32'd0;
        endcase
    end

    // entry stage: |bound - origin|, |dir|, quotient sign, zero-dir and in-slab checks
    always_comb begin
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        logic signed [31:0] bnd;
        logic [32:0]        diff;
        org[0] = i_in_data.origin_x;
        org[1] = i_in_data.origin_y;
        org[2] = i_in_data.origin_z;
        dir[0] = i_in_data.dir_x;
        dir[1] = i_in_data.dir_y;
        dir[2] = i_in_data.dir_z;
        n_s[0] = '0;
        n_s[0].lo = -rbs3d_pkg::FULL;
        n_s[0].hi = rbs3d_pkg::FULL;
        n_s[0].ok = 1'b1;
        for (int a = 0; a < 3; a++) begin
            n_s[0].dzero[a]   = (dir[a] == 32'sd0);
            n_s[0].dneg[a]    = dir[a][31];
            n_s[0].in_slab[a] = !(org[a] < r_box_min[a] || org[a] > r_box_max[a]);
            for (int b = 0; b < 2; b++) begin
                bnd  = (b == 1) ? r_box_max[a] : r_box_min[a];
                diff = {bnd[31], bnd} - {org[a][31], org[a]};
                n_s[0].dv[2*a+b].rem  = diff[32] ? 32'(~diff + 33'd1) : diff[31:0];
                n_s[0].dv[2*a+b].dmag = dir[a][31] ? (~dir[a] + 32'd1) : dir[a];
                n_s[0].dv[2*a+b].neg  = diff[32] ^ dir[a][31];
            end
        end
    end

    // range check: quotient of (mag << 16) / dmag reaches 2^31
    always_comb begin
        n_s[1] = r_s[0];
        for (int i = 0; i < 6; i++) begin
            n_s[1].dv[i].ovf = {15'd0, r_s[0].dv[i].rem[31:15]} >= r_s[0].dv[i].dmag;
            n_s[1].dv[i].rem = {15'd0, r_s[0].dv[i].rem[31:15]};
            n_s[1].dv[i].dvd = {r_s[0].dv[i].rem[14:0], 16'd0};
            n_s[1].dv[i].q   = '0;
        end
    end

    for (genvar k = 0; k < NDS; k++) begin : g_div
        always_comb begin
            n_s[S_DIV0+k] = r_s[S_DIV0+k-1];
            for (int j = 0; j < SPS; j++) begin
                if (k * SPS + j < QBITS) begin
                    for (int i = 0; i < 6; i++)
                        n_s[S_DIV0+k].dv[i] = rbs3d_pkg::div_step(n_s[S_DIV0+k].dv[i]);
                end
            end
        end
    end

    // sign and saturation
    always_comb begin
        n_s[S_SIGN] = r_s[S_SIGN-1];
        for (int i = 0; i < 6; i++) begin
            if (r_s[S_SIGN-1].dv[i].ovf)
                n_s[S_SIGN].t[i] = r_s[S_SIGN-1].dv[i].neg ? -rbs3d_pkg::FULL
                                                           : rbs3d_pkg::FULL;
            else if (r_s[S_SIGN-1].dv[i].neg)
                n_s[S_SIGN].t[i] = -{1'b0, r_s[S_SIGN-1].dv[i].q};
            else
                n_s[S_SIGN].t[i] = {1'b0, r_s[S_SIGN-1].dv[i].q};
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        always_comb begin
            n_s[S_AX0+a] = rbs3d_pkg::axis_step(r_s[S_AX0+a-1], 2'(a));
        end
    end

    always_comb begin
        n_o.hit     = r_s[NS-1].ok;
        n_o.t_entry = r_s[NS-1].ok ? r_s[NS-1].lo : 32'sd0;
        n_o.t_exit  = r_s[NS-1].ok ? r_s[NS-1].hi : 32'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[NS-2:0], in_xfer};
            r_ov <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NS; k++) r_s[k] <= n_s[k];
            r_o <= n_o;
        end
    end

    `RBS_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.hit,
        o_out_data.t_entry == 32'sd0 && o_out_data.t_exit == 32'sd0)
    `RBS_ASSERT_IMP(a_hit_order, i_clk, i_rst_n, o_out_valid && o_out_data.hit,
        o_out_data.t_entry <= o_out_data.t_exit)
    `RBS_ASSERT_NEXT(a_enter, i_clk, i_rst_n, i_in_valid && o_in_ready, r_v[0])

endmodule
